>>> src/assert_macros.svh
// Assertion macros shared by the attitude controller RTL.
// No dependencies; include in any module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted, with a given message.
`define QPD_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check with the default message.
`define QPD_ASSERT(lbl, prop) \
    `QPD_ASSERT_MSG(lbl, prop, "qpd check failed")

`endif

>>> src/qpd_pkg.sv
// Shared types and constants for the quaternion PD attitude controller.
// No dependencies.
`timescale 1ns / 1ps

package qpd_pkg;

    localparam int SQ_STAGES = 17;   // one root bit per stage
    localparam int DV_STAGES = 15;   // one quotient bit per stage

    typedef logic signed [15:0] q16_t;

    typedef struct packed {
        q16_t        rate_x;
        q16_t        rate_y;
        q16_t        rate_z;
        q16_t        want_w;
        q16_t        want_x;
        q16_t        want_y;
        q16_t        want_z;
        logic [15:0] thrust;
    } side_t;

    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

    localparam logic CFG_ATT_GAIN  = 1'b0;
    localparam logic CFG_RATE_GAIN = 1'b1;

    localparam logic [15:0] GAIN_RESET = 16'd256;

endpackage

>>> src/qpd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qpd_pkg.
`timescale 1ns / 1ps

module qpd_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  qpd_pkg::pipe_ctl_t ctl,
    input  logic [32:0]       radicand,
    output logic              root_vld,
    output logic [16:0]       root
);
    import qpd_pkg::*;

    localparam int RW = 34;

    logic [RW-1:0] rem_reg [0:SQ_STAGES-1];
    logic [RW-1:0] res_reg [0:SQ_STAGES-1];
    logic          vld_reg [0:SQ_STAGES-1];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (2 * (SQ_STAGES - 1 - g));
        logic [RW-1:0] rem_in;
        logic [RW-1:0] res_in;
        logic          vld_in;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [RW-1:0] res_next;

        if (g == 0) begin : g_first
            assign rem_in = {1'b0, radicand};
            assign res_in = '0;
            assign vld_in = ctl.vld;
        end
        else begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign res_in = res_reg[g-1];
            assign vld_in = vld_reg[g-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (ctl.en)
                vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[g] <= rem_next;
                res_reg[g] <= res_next;
            end
        end
    end

    assign root_vld = vld_reg[SQ_STAGES-1];
    assign root     = res_reg[SQ_STAGES-1][16:0];

endmodule

>>> src/qpd_ndiv.sv
// Four-lane pipelined restoring divider that normalizes a quaternion:
// round(c * 2^14 / n), ties away from zero; a zero norm gives zero.
// Depends on qpd_pkg.
`timescale 1ns / 1ps

module qpd_ndiv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qpd_pkg::pipe_ctl_t    ctl,
    input  qpd_pkg::q16_t [3:0]   cur,
    input  logic [16:0]           norm_len,
    output logic                  norm_vld,
    output qpd_pkg::q16_t [3:0]   norm
);
    import qpd_pkg::*;

    logic [30:0] rem_reg [0:DV_STAGES-1][0:3];
    logic [14:0] q_reg   [0:DV_STAGES-1][0:3];
    logic [3:0]  neg_reg [0:DV_STAGES-1];
    logic [16:0] n_reg   [0:DV_STAGES-1];
    logic        vld_reg [0:DV_STAGES-1];

    for (genvar g = 0; g < DV_STAGES; g++) begin : g_stage
        localparam int K = DV_STAGES - 1 - g;
        logic [30:0] rem_in  [0:3];
        logic [14:0] q_in    [0:3];
        logic [30:0] rem_nx  [0:3];
        logic [14:0] q_nx    [0:3];
        logic [3:0]  neg_in;
        logic [16:0] n_in;
        logic        vld_in;
        logic [30:0] dsh;

        if (g == 0) begin : g_first
            always_comb
            begin
                logic [15:0] mag;
                for (int l = 0; l < 4; l++)
                begin
                    mag       = cur[l][15] ? 16'(-cur[l]) : cur[l];
                    rem_in[l] = {1'b0, mag, 14'b0} + 31'(norm_len[16:1]);
                    q_in[l]   = '0;
                    neg_in[l] = cur[l][15];
                end
            end
            assign n_in   = norm_len;
            assign vld_in = ctl.vld;
        end
        else begin : g_rest
            always_comb
            begin
                for (int l = 0; l < 4; l++)
                begin
                    rem_in[l] = rem_reg[g-1][l];
                    q_in[l]   = q_reg[g-1][l];
                end
            end
            assign neg_in = neg_reg[g-1];
            assign n_in   = n_reg[g-1];
            assign vld_in = vld_reg[g-1];
        end

        always_comb
        begin
            dsh = {14'b0, n_in} << K;
            for (int l = 0; l < 4; l++)
            begin
                if (rem_in[l] >= dsh)
                begin
                    rem_nx[l] = rem_in[l] - dsh;
                    q_nx[l]   = q_in[l] | (15'd1 << K);
                end
                else
                begin
                    rem_nx[l] = rem_in[l];
                    q_nx[l]   = q_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (ctl.en)
                vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    rem_reg[g][l] <= rem_nx[l];
                    q_reg[g][l]   <= q_nx[l];
                end
                neg_reg[g] <= neg_in;
                n_reg[g]   <= n_in;
            end
        end
    end

    // Apply sign; a zero norm means a zero quaternion, which stays zero.
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (n_reg[DV_STAGES-1] == '0)
                norm[l] = '0;
            else if (neg_reg[DV_STAGES-1][l])
                norm[l] = 16'(-{1'b0, q_reg[DV_STAGES-1][l]});
            else
                norm[l] = {1'b0, q_reg[DV_STAGES-1][l]};
        end
    end

    assign norm_vld = vld_reg[DV_STAGES-1];

endmodule

>>> src/quaternion_pd_attitude_control_unit.sv
// Quaternion-error PD attitude controller, top level.
// Depends on qpd_pkg, qpd_isqrt, qpd_ndiv and assert_macros.svh.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    cur_*, rate_*, want_*, thrust_ref
//   result    out        out_valid / out_ready  thrust_cmd, torque_x/y/z
//   config    in         cfg_wr_en              cfg_index, cfg_data
//
// One transaction enters per cycle unless the pipeline holds; from
// acceptance to result it passes the squares and sum stages, the root, the
// divider, the cross products, error sum, gain multiply and output register.
// The whole pipeline advances together; it holds whenever the output register
// is full and not taken, so a stall drops and repeats nothing.
// Reset clears valid bits and loads both gains with 1.0 (256 in Q8.8).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quaternion_pd_attitude_control_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [15:0] cur_w,
    input  logic signed [15:0] cur_x,
    input  logic signed [15:0] cur_y,
    input  logic signed [15:0] cur_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    input  logic signed [15:0] want_w,
    input  logic signed [15:0] want_x,
    input  logic signed [15:0] want_y,
    input  logic signed [15:0] want_z,
    input  logic [15:0] thrust_ref,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] thrust_cmd,
    output logic signed [23:0] torque_x,
    output logic signed [23:0] torque_y,
    output logic signed [23:0] torque_z
);
    import qpd_pkg::*;

    localparam int LINE = SQ_STAGES + DV_STAGES;

    logic [15:0] att_gain_reg;
    logic [15:0] rate_gain_reg;

    logic        en;
    logic        accept;
    side_t       side_in;
    q16_t [3:0]  cur_in;

    // squares stage
    logic        a_vld_reg;
    logic [30:0] sq_reg [0:3];
    q16_t [3:0]  cur_a_reg;
    side_t       side_a_reg;

    // sum stage
    logic        b_vld_reg;
    logic [32:0] sum_reg;
    q16_t [3:0]  cur_b_reg;
    side_t       side_b_reg;

    // delay lines beside the root and divider
    q16_t [3:0]  cur_line_reg  [0:SQ_STAGES-1];
    side_t       side_line_reg [0:LINE-1];

    pipe_ctl_t   sq_ctl;
    pipe_ctl_t   dv_ctl;
    logic        root_vld;
    logic [16:0] root;
    logic        div_vld;
    q16_t [3:0]  norm;
    logic        norm_ok;

    // product stage
    logic               p_vld_reg;
    logic signed [31:0] prod_reg [0:3][0:3];
    side_t              side_p_reg;

    // error sum stage
    logic               s_vld_reg;
    logic signed [33:0] ew_reg;
    logic signed [33:0] ev_reg [0:2];
    side_t              side_s_reg;
    logic signed [33:0] ew_next;
    logic signed [33:0] ev_next [0:2];

    // gain multiply stage
    logic               m_vld_reg;
    logic signed [50:0] att_prod_reg [0:2];
    logic signed [32:0] rate_prod_reg [0:2];
    logic [15:0]        thrust_m_reg;
    logic signed [15:0] rate_sel [0:2];
    logic signed [33:0] pe [0:2];

    // output register
    logic               out_valid_reg;
    logic [15:0]        thrust_reg;
    logic signed [23:0] torque_reg [0:2];
    logic signed [23:0] torque_next [0:2];

    // Advance when the output register is empty or being emptied.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    assign cur_in  = {cur_z, cur_y, cur_x, cur_w};
    assign side_in = '{rate_x: rate_x, rate_y: rate_y, rate_z: rate_z,
                       want_w: want_w, want_x: want_x, want_y: want_y,
                       want_z: want_z, thrust: thrust_ref};

    // Configuration writes must arrive only while idle; nothing enforces it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_gain_reg  <= GAIN_RESET;
            rate_gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ATT_GAIN:  att_gain_reg  <= cfg_data;
                CFG_RATE_GAIN: rate_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits for the stages kept in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            s_vld_reg     <= 1'b0;
            m_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg     <= accept;
            b_vld_reg     <= a_vld_reg;
            p_vld_reg     <= div_vld;
            s_vld_reg     <= p_vld_reg;
            m_vld_reg     <= s_vld_reg;
            out_valid_reg <= m_vld_reg;
        end
    end

    // Squares and their exact sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= 31'(cur_in[i] * cur_in[i]);
            cur_a_reg  <= cur_in;
            side_a_reg <= side_in;
            sum_reg    <= 33'(sq_reg[0]) + 33'(sq_reg[1]) + 33'(sq_reg[2]) + 33'(sq_reg[3]);
            cur_b_reg  <= cur_a_reg;
            side_b_reg <= side_a_reg;
        end
    end

    // Carry the raw quaternion and the sideband past the root and divider.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cur_line_reg[0]  <= cur_b_reg;
            side_line_reg[0] <= side_b_reg;
            for (int k = 1; k < SQ_STAGES; k++)
                cur_line_reg[k] <= cur_line_reg[k-1];
            for (int k = 1; k < LINE; k++)
                side_line_reg[k] <= side_line_reg[k-1];
        end
    end

    assign sq_ctl = '{en: en, vld: b_vld_reg};
    assign dv_ctl = '{en: en, vld: root_vld};

    qpd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sq_ctl),
        .radicand (sum_reg),
        .root_vld (root_vld),
        .root     (root)
    );

    qpd_ndiv u_ndiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dv_ctl),
        .cur      (cur_line_reg[SQ_STAGES-1]),
        .norm_len (root),
        .norm_vld (div_vld),
        .norm     (norm)
    );

    // All sixteen cross products of normalized current and desired attitude.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i][0] <= norm[i] * side_line_reg[LINE-1].want_w;
                prod_reg[i][1] <= norm[i] * side_line_reg[LINE-1].want_x;
                prod_reg[i][2] <= norm[i] * side_line_reg[LINE-1].want_y;
                prod_reg[i][3] <= norm[i] * side_line_reg[LINE-1].want_z;
            end
            side_p_reg <= side_line_reg[LINE-1];
        end
    end

    // Error quaternion conj(c) * d at scale 2^28.
    always_comb
    begin
        ew_next    = 34'(prod_reg[0][0]) + 34'(prod_reg[1][1])
                   + 34'(prod_reg[2][2]) + 34'(prod_reg[3][3]);
        ev_next[0] = 34'(prod_reg[0][1]) - 34'(prod_reg[1][0])
                   - 34'(prod_reg[2][3]) + 34'(prod_reg[3][2]);
        ev_next[1] = 34'(prod_reg[0][2]) - 34'(prod_reg[2][0])
                   - 34'(prod_reg[3][1]) + 34'(prod_reg[1][3]);
        ev_next[2] = 34'(prod_reg[0][3]) - 34'(prod_reg[3][0])
                   - 34'(prod_reg[1][2]) + 34'(prod_reg[2][1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ew_reg     <= ew_next;
            ev_reg     <= ev_next;
            side_s_reg <= side_p_reg;
        end
    end

    // Flip for the shortest rotation, then scale by the gains.
    always_comb
    begin
        rate_sel[0] = side_s_reg.rate_x;
        rate_sel[1] = side_s_reg.rate_y;
        rate_sel[2] = side_s_reg.rate_z;
        for (int i = 0; i < 3; i++)
            pe[i] = ew_reg[33] ? 34'(-ev_reg[i]) : ev_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                att_prod_reg[i]  <= $signed({1'b0, att_gain_reg}) * pe[i];
                rate_prod_reg[i] <= $signed({1'b0, rate_gain_reg}) * rate_sel[i];
            end
            thrust_m_reg <= side_s_reg.thrust;
        end
    end

    // Sum at scale 2^36, round half up to scale 2^10, saturate to 24 bits.
    always_comb
    begin
        logic signed [51:0] acc;
        logic signed [25:0] t;
        for (int i = 0; i < 3; i++)
        begin
            acc = 52'(att_prod_reg[i]) - (52'(rate_prod_reg[i]) <<< 18)
                + 52'sd33554432;
            t   = acc[51:26];
            if (t > 26'sd8388607)
                torque_next[i] = 24'sh7FFFFF;
            else if (t < -26'sd8388608)
                torque_next[i] = 24'sh800000;
            else
                torque_next[i] = t[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            torque_reg <= torque_next;
            thrust_reg <= thrust_m_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign thrust_cmd = thrust_reg;
    assign torque_x   = torque_reg[0];
    assign torque_y   = torque_reg[1];
    assign torque_z   = torque_reg[2];

    // Every normalized component lies within plus or minus one in Q1.14.
    always_comb
    begin
        norm_ok = 1'b1;
        for (int i = 0; i < 4; i++)
            if (norm[i] > 16'sd16384 || norm[i] < -16'sd16384)
                norm_ok = 1'b0;
    end

    // A normalized component never exceeds one in Q1.14.
    `QPD_ASSERT(a_norm_range, div_vld |-> norm_ok)
    // A finished transaction lands in the output register when the pipe moves.
    `QPD_ASSERT(a_out_load, (m_vld_reg && en) |=> out_valid_reg)
    // A held pipeline keeps its inner valid bits.
    `QPD_ASSERT(a_freeze, !en |=> ($stable(p_vld_reg) && $stable(s_vld_reg)))

endmodule

>>> test/qpd_checker.sv
// Scoreboard for the quaternion PD controller: watches all three channels,
// predicts each result from the accepted transaction, compares field by field.
// Depends on qpd_pkg for the register index constants and gain reset value.
`timescale 1ns / 1ps

module qpd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] cur_w,
    input  logic signed [15:0] cur_x,
    input  logic signed [15:0] cur_y,
    input  logic signed [15:0] cur_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    input  logic signed [15:0] want_w,
    input  logic signed [15:0] want_x,
    input  logic signed [15:0] want_y,
    input  logic signed [15:0] want_z,
    input  logic [15:0]        thrust_ref,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [15:0]        thrust_cmd,
    input  logic signed [23:0] torque_x,
    input  logic signed [23:0] torque_y,
    input  logic signed [23:0] torque_z,
    output int                 fail_count,
    output int                 pending,
    output int                 seen_count
);
    import qpd_pkg::*;

    typedef struct {
        logic [15:0]        thrust;
        logic signed [23:0] tq [3];
    } cmd_t;

    cmd_t            cmd_queue [$];
    logic [15:0]     att_gain;
    logic [15:0]     damp_gain;

    function automatic longint root_floor(longint s);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= s)
                r = r + (64'sd1 << b);
        return r;
    endfunction

    function automatic longint ratio_round(longint num, longint den);
        longint m;
        m = (num < 0) ? -num : num;
        m = (m + den / 2) / den;
        return (num < 0) ? -m : m;
    endfunction

    function automatic logic signed [23:0] sat_round(longint acc);
        longint t;
        t = (acc + (64'sd1 << 25)) >>> 26;   // arithmetic shift gives floor
        if (t > 64'sd8388607)  t = 64'sd8388607;
        if (t < -64'sd8388608) t = -64'sd8388608;
        return t[23:0];
    endfunction

    function automatic cmd_t predict_command(longint q[4], longint d[4], longint w[3],
                                             logic [15:0] thr);
        cmd_t   c;
        longint s, n, ew, pe, acc;
        longint ev [3];
        s = 0;
        for (int i = 0; i < 4; i++) s += q[i] * q[i];
        if (s != 0)
        begin
            n = root_floor(s);
            for (int i = 0; i < 4; i++) q[i] = ratio_round(q[i] * 16384, n);
        end
        ew    = q[0]*d[0] + q[1]*d[1] + q[2]*d[2] + q[3]*d[3];
        ev[0] = q[0]*d[1] - d[0]*q[1] - (q[2]*d[3] - q[3]*d[2]);
        ev[1] = q[0]*d[2] - d[0]*q[2] - (q[3]*d[1] - q[1]*d[3]);
        ev[2] = q[0]*d[3] - d[0]*q[3] - (q[1]*d[2] - q[2]*d[1]);
        c.thrust = thr;
        for (int i = 0; i < 3; i++)
        begin
            pe  = (ew < 0) ? -ev[i] : ev[i];
            acc = longint'(att_gain) * pe - longint'(damp_gain) * w[i] * 262144;
            c.tq[i] = sat_round(acc);
        end
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t   got, exp_c;
        longint q [4];
        longint d [4];
        longint w [3];
        int     errs;
        errs = 0;
        if (!rst_n)
        begin
            att_gain   <= GAIN_RESET;
            damp_gain  <= GAIN_RESET;
            fail_count <= 0;
            seen_count <= 0;
            pending    <= 0;
            cmd_queue.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_ATT_GAIN) att_gain  <= cfg_data;
                else                           damp_gain <= cfg_data;
            end
            if (in_valid && in_ready)
            begin
                q = '{cur_w, cur_x, cur_y, cur_z};
                d = '{want_w, want_x, want_y, want_z};
                w = '{rate_x, rate_y, rate_z};
                cmd_queue.push_back(predict_command(q, d, w, thrust_ref));
            end
            if (out_valid && out_ready)
            begin
                seen_count <= seen_count + 1;
                if (cmd_queue.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    errs++;
                end
                else
                begin
                    exp_c = cmd_queue.pop_front();
                    got.thrust = thrust_cmd;
                    got.tq = '{torque_x, torque_y, torque_z};
                    if (got.thrust !== exp_c.thrust)
                    begin
                        $error("thrust_cmd expected %0d got %0d", exp_c.thrust, got.thrust);
                        errs++;
                    end
                    for (int i = 0; i < 3; i++)
                        if (got.tq[i] !== exp_c.tq[i])
                        begin
                            $error("torque_%s expected %0d got %0d",
                                   (i == 0) ? "x" : (i == 1) ? "y" : "z",
                                   exp_c.tq[i], got.tq[i]);
                            errs++;
                        end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            pending <= cmd_queue.size();
        end
    end
endmodule

>>> test/tb_quaternion_pd_attitude_control_unit.sv
// Testbench top for the quaternion PD attitude controller: makes stimulus,
// drives configuration and stalls, and gives the verdict. Uses qpd_checker, qpd_pkg.
`timescale 1ns / 1ps

module tb_quaternion_pd_attitude_control_unit;
    import qpd_pkg::*;

    localparam int LATENCY    = 38;
    localparam int WATCH_MAX  = 20000;
    localparam int RAND_ITEMS = 1950;

    logic clk, rst_n;
    logic cfg_wr_en, cfg_index;
    logic [15:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] cur_w, cur_x, cur_y, cur_z, rate_x, rate_y, rate_z;
    logic signed [15:0] want_w, want_x, want_y, want_z;
    logic [15:0] thrust_ref, thrust_cmd;
    logic signed [23:0] torque_x, torque_y, torque_z;
    int fail_count, pending, seen_count;

    // Receiver behavior: 0 random stalls, 1 never stall, 2 long hold-off.
    int  sink_mode;
    int  idle_cycles;
    bit  done_stim;
    int  sent;

    quaternion_pd_attitude_control_unit u_dut (.*);
    qpd_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall with chance 27 percent, except in the quiet and hold-off phases.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_mode == 2)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                sink_mode = 0;
            end
            out_ready <= (sink_mode == 1) ? 1'b1 : ($urandom_range(99) >= 27);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCH_MAX)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_gain(logic idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Drop the input, hold until every outstanding transaction has drained,
    // then the pipe tail.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Offer one transaction and hold it until accepted; gap first when asked.
    task automatic send_item(logic [15:0] f [12], bit gaps);
        while (gaps && ($urandom_range(99) < 27))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cur_w <= f[0];  cur_x <= f[1];  cur_y <= f[2];  cur_z <= f[3];
        rate_x <= f[4]; rate_y <= f[5]; rate_z <= f[6];
        want_w <= f[7]; want_x <= f[8]; want_y <= f[9]; want_z <= f[10];
        thrust_ref <= f[11];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // Mostly components in +-8000, small rates; else zero, identical or raw noise.
    function automatic void rand_fields(ref logic [15:0] f [12]);
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 12; i++) f[i] = 16'($urandom);
        if (kind < 6)
        begin
            for (int i = 0; i < 4; i++)  f[i]   = $signed(16'($urandom_range(16000))) - 16'sd8000;
            for (int i = 4; i < 7; i++)  f[i]   = $signed(16'($urandom_range(4000))) - 16'sd2000;
            for (int i = 7; i < 11; i++) f[i]   = $signed(16'($urandom_range(16000))) - 16'sd8000;
        end
        else if (kind == 6)
            for (int i = 0; i < 4; i++) f[i] = 16'sd0;   // zero current quaternion
        else if (kind == 7)
            for (int i = 7; i < 11; i++) f[i] = f[i - 7]; // identical attitudes
    endfunction

    initial
    begin
        logic [15:0] f [12];
        logic [15:0] gains [5][2];
        cfg_wr_en = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        in_valid = 1'b0;
        {cur_w, cur_x, cur_y, cur_z, rate_x, rate_y, rate_z} = '0;
        {want_w, want_x, want_y, want_z, thrust_ref} = '0;
        sink_mode = 1; sent = 0; done_stim = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset gains, no stalls.
        f = '{default: 16'h0000};
        send_item(f, 0);                         // zero current quaternion, zero rate
        f = '{16'sd16384, 0, 0, 0, 16'sd100, -16'sd100, 16'sd0,
              16'sd16384, 0, 0, 0, 16'hFFFF};
        send_item(f, 0);                         // identity error
        f = '{16'sd16384, 0, 0, 0, 0, 0, 0, 0, 16'sd16384, 0, 0, 16'd1};
        send_item(f, 0);                         // error scalar exactly zero
        f = '{16'sd16384, 0, 0, 0, 0, 0, 0, -16'sd16384, 16'sd4000, 0, 0, 16'd7};
        send_item(f, 0);                         // negative scalar, flip
        f = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
              16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000};
        send_item(f, 0);
        f = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        send_item(f, 0);
        f = '{0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1000, 16'sd30000, -16'sd30000, 16'sd5, 0};
        send_item(f, 0);                         // tiny norm, non-unit desired
        drain_pipe();

        // Extreme gains to force saturation, then both gains set to zero.
        write_gain(CFG_ATT_GAIN, 16'hFFFF);
        write_gain(CFG_RATE_GAIN, 16'hFFFF);
        f = '{16'h7FFF, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h0000,
              16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234};
        send_item(f, 0);
        f = '{16'sd16384, 0, 0, 0, 16'h7FFF, 16'h8000, 16'sd1, 16'sd0,
              16'sd16384, 0, 0, 16'h8000};
        send_item(f, 0);
        drain_pipe();
        write_gain(CFG_ATT_GAIN, 16'h0000);
        write_gain(CFG_RATE_GAIN, 16'h0000);
        send_item(f, 0);
        drain_pipe();

        // Random phases over a set of gain settings.
        gains = '{'{16'd256, 16'd256}, '{16'hFFFF, 16'h0000}, '{16'h0000, 16'hFFFF},
                  '{16'd1, 16'd40}, '{16'd0, 16'd0}};
        for (int p = 0; p < 5; p++)
        begin
            write_gain(CFG_ATT_GAIN,  (p == 4) ? 16'($urandom) : gains[p][0]);
            write_gain(CFG_RATE_GAIN, (p == 4) ? 16'($urandom) : gains[p][1]);
            // Phase 1: long hold-off so the pipeline fills and stalls its input.
            sink_mode = (p == 1) ? 2 : (p == 2) ? 1 : 0;
            for (int k = 0; k < RAND_ITEMS / 5; k++)
            begin
                rand_fields(f);
                send_item(f, p != 2);
            end
            drain_pipe();
        end
        done_stim = 1;

        $display("covered %0d transactions over several gain settings, with stalls", sent);
        $display("and a full-pipeline hold-off; %0d results compared", seen_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/qpd_pkg.sv
src/qpd_isqrt.sv
src/qpd_ndiv.sv
src/quaternion_pd_attitude_control_unit.sv
test/qpd_checker.sv
test/tb_quaternion_pd_attitude_control_unit.sv
